// ===== sv/scbc_pkg.sv =====
package scbc_pkg;

  // Field widths of the pixel transactions.
  localparam int PIXEL_W     = 8;
  localparam int COLUMN_W    = 9;
  localparam int ROW_W       = 8;
  localparam int FRAME_W     = 16;
  localparam int DRAW_SLOT_W = 4;
  localparam int OFFSET_W    = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int COUNT_W    = 5;
  localparam int RADIUS_W   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT     = 3'd0,
    CFG_REQUIRED_MATCHES = 3'd1,
    CFG_MATCH_RADIUS     = 3'd2,
    CFG_IMAGE_WIDTH      = 3'd3,
    CFG_IMAGE_HEIGHT     = 3'd4
  } cfg_idx_e;

  localparam logic [COUNT_W-1:0]  RST_SAMPLE_COUNT     = 5'd16;
  localparam logic [COUNT_W-1:0]  RST_REQUIRED_MATCHES = 5'd2;
  localparam logic [RADIUS_W-1:0] RST_MATCH_RADIUS     = 8'd20;
  localparam logic [COLUMN_W-1:0] RST_IMAGE_WIDTH      = 9'd320;
  localparam logic [ROW_W-1:0]    RST_IMAGE_HEIGHT     = 8'd240;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_NBR
  } state_e;

endpackage

// ===== sv/scbc_pixel_if.sv =====
interface scbc_pixel_if;
  import scbc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [PIXEL_W-1:0]            pixel;
  logic [COLUMN_W-1:0]           column;
  logic [ROW_W-1:0]              row;
  logic [FRAME_W-1:0]            frame_number;
  logic                          self_update;
  logic [DRAW_SLOT_W-1:0]        self_slot;
  logic                          neighbor_update;
  logic signed [OFFSET_W-1:0]    neighbor_dx;
  logic signed [OFFSET_W-1:0]    neighbor_dy;
  logic [DRAW_SLOT_W-1:0]        neighbor_slot;

  modport source (
    output valid, pixel, column, row, frame_number, self_update, self_slot,
           neighbor_update, neighbor_dx, neighbor_dy, neighbor_slot,
    input  ready
  );

  modport sink (
    input  valid, pixel, column, row, frame_number, self_update, self_slot,
           neighbor_update, neighbor_dx, neighbor_dy, neighbor_slot,
    output ready
  );

endinterface

// ===== sv/scbc_result_if.sv =====
interface scbc_result_if;

  logic valid;
  logic ready;
  logic foreground;
  logic learning;

  modport source (output valid, foreground, learning, input ready);
  modport sink (input valid, foreground, learning, output ready);

endinterface

// ===== sv/scbc_sample_mem.sv =====
module scbc_sample_mem #(
  parameter int DEPTH  = 76800,
  parameter int LANES  = 16,
  parameter int ADDR_W = 17
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ADDR_W-1:0]             waddr_i,
  input  logic [LANES-1:0]              be_i,
  input  logic [scbc_pkg::PIXEL_W-1:0]  wdata_i,
  input  logic                          re_i,
  input  logic [ADDR_W-1:0]             raddr_i,
  output logic [LANES-1:0][scbc_pkg::PIXEL_W-1:0] rdata_o
);
  import scbc_pkg::*;

  // One row holds every sample of one pixel position; each sample is a byte lane.
  logic [LANES-1:0][PIXEL_W-1:0] mem_q [DEPTH];
  logic [LANES-1:0][PIXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < LANES; b++) begin
        if (be_i[b]) begin
          mem_q[waddr_i][b] <= wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/scbc_match.sv =====
module scbc_match #(
  parameter int LANES = 16,
  parameter int CNT_W = 5
) (
  input  logic [LANES-1:0][scbc_pkg::PIXEL_W-1:0] samples_i,
  input  logic [scbc_pkg::PIXEL_W-1:0]            pixel_i,
  input  logic [scbc_pkg::RADIUS_W-1:0]           radius_i,
  input  logic [CNT_W-1:0]                        count_i,
  input  logic [scbc_pkg::COUNT_W-1:0]            required_i,
  output logic                                    background_o
);
  import scbc_pkg::*;

  logic [LANES-1:0]   hits;
  logic [PIXEL_W-1:0] diff [LANES];
  logic [CNT_W-1:0]   hit_cnt;

  // Each lane compares independently; only lanes below the active count vote.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff[i] = (pixel_i > samples_i[i]) ? pixel_i - samples_i[i]
                                         : samples_i[i] - pixel_i;
      hits[i] = (CNT_W'(i) < count_i) && (diff[i] < radius_i);
    end
  end

  assign hit_cnt      = CNT_W'($countones(hits));
  assign background_o = (8'(hit_cnt) >= 8'(required_i));

endmodule

// ===== sv/sample_consensus_background_classifier_top.sv =====
// Sample-consensus background classifier. Each pixel position owns one row of
// MAX_SAMPLES grey samples in a single on-chip memory (MAX_WIDTH*MAX_HEIGHT rows,
// one write and one read port, registered read data); the memory is not
// cleared, so every slot that is compared must have been learned first. A
// learning pixel is a direct byte write; a classified pixel reads its row,
// then compares and writes its own sample, and takes a further S_NBR step when
// it also refreshes a neighbor sample, because that second write needs its own
// turn on the single write port. The next pixel is taken once the previous
// one has retired its writes and the result register is free or being read.
module sample_consensus_background_classifier_top #(
  parameter int MAX_WIDTH   = 320,
  parameter int MAX_HEIGHT  = 240,
  parameter int MAX_SAMPLES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [scbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [scbc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  scbc_pixel_if.sink                        in_i,
  scbc_result_if.source                     out_o
);
  import scbc_pkg::*;

  localparam int SLOT_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int POS_X_W = $clog2(MAX_WIDTH);
  localparam int POS_Y_W = $clog2(MAX_HEIGHT);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);

  // Configuration registers.
  logic [COUNT_W-1:0]  sample_count_q, required_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [COLUMN_W-1:0] width_q;
  logic [ROW_W-1:0]    height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= RST_SAMPLE_COUNT;
      required_q     <= RST_REQUIRED_MATCHES;
      radius_q       <= RST_MATCH_RADIUS;
      width_q        <= RST_IMAGE_WIDTH;
      height_q       <= RST_IMAGE_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_COUNT:     sample_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_REQUIRED_MATCHES: required_q     <= cfg_data_i[COUNT_W-1:0];
        CFG_MATCH_RADIUS:     radius_q       <= cfg_data_i[RADIUS_W-1:0];
        CFG_IMAGE_WIDTH:      width_q        <= cfg_data_i[COLUMN_W-1:0];
        CFG_IMAGE_HEIGHT:     height_q       <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective count and image bounds.
  logic [CNT_W-1:0]    n_eff;
  logic [COLUMN_W-1:0] width_nz;
  logic [ROW_W-1:0]    height_nz;
  logic [POS_X_W-1:0]  x_max;
  logic [POS_Y_W-1:0]  y_max;

  always_comb begin
    n_eff = (16'(sample_count_q) > 16'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                     : CNT_W'(sample_count_q);
    width_nz  = (width_q == '0) ? COLUMN_W'(1) : width_q;
    height_nz = (height_q == '0) ? ROW_W'(1) : height_q;
    x_max = (16'(width_nz) > 16'(MAX_WIDTH)) ? POS_X_W'(MAX_WIDTH - 1)
                                             : POS_X_W'(width_nz - COLUMN_W'(1));
    y_max = (16'(height_nz) > 16'(MAX_HEIGHT)) ? POS_Y_W'(MAX_HEIGHT - 1)
                                               : POS_Y_W'(height_nz - ROW_W'(1));
  end

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_fg_q, out_fg_d, out_learn_q, out_learn_d;

  logic                accept, is_learn;
  logic [POS_X_W-1:0]  col_c;
  logic [POS_Y_W-1:0]  row_c;
  logic [ADDR_W-1:0]   own_addr_c;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign is_learn   = (in_i.frame_number < FRAME_W'(n_eff));

  always_comb begin
    col_c = (16'(in_i.column) > 16'(x_max)) ? x_max : POS_X_W'(in_i.column);
    row_c = (16'(in_i.row) > 16'(y_max)) ? y_max : POS_Y_W'(in_i.row);
    own_addr_c = ADDR_W'(row_c) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_c);
  end

  // Item held while it is classified and its samples are refreshed.
  logic [PIXEL_W-1:0]         pix_q;
  logic [POS_X_W-1:0]         col_q;
  logic [POS_Y_W-1:0]         row_q;
  logic [ADDR_W-1:0]          own_addr_q, nb_addr_q, nb_addr_d;
  logic                       self_upd_q, nb_upd_q;
  logic [DRAW_SLOT_W-1:0]     self_slot_q, nb_slot_q;
  logic signed [OFFSET_W-1:0] nb_dx_q, nb_dy_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q       <= in_i.pixel;
      col_q       <= col_c;
      row_q       <= row_c;
      own_addr_q  <= own_addr_c;
      self_upd_q  <= in_i.self_update;
      self_slot_q <= in_i.self_slot;
      nb_upd_q    <= in_i.neighbor_update;
      nb_slot_q   <= in_i.neighbor_slot;
      nb_dx_q     <= in_i.neighbor_dx;
      nb_dy_q     <= in_i.neighbor_dy;
    end
    if (state_q == S_EVAL) begin
      nb_addr_q <= nb_addr_d;
    end
  end

  // Neighbor position, clamped to the image.
  logic signed [15:0] nx_s, ny_s;
  logic [POS_X_W-1:0] nx;
  logic [POS_Y_W-1:0] ny;

  always_comb begin
    nx_s = $signed(16'(col_q)) + 16'(nb_dx_q);
    ny_s = $signed(16'(row_q)) + 16'(nb_dy_q);
    if (nx_s[15]) begin
      nx = '0;
    end else if (nx_s > $signed(16'(x_max))) begin
      nx = x_max;
    end else begin
      nx = POS_X_W'(nx_s);
    end
    if (ny_s[15]) begin
      ny = '0;
    end else if (ny_s > $signed(16'(y_max))) begin
      ny = y_max;
    end else begin
      ny = POS_Y_W'(ny_s);
    end
    nb_addr_d = ADDR_W'(ny) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nx);
  end

  // Sample memory and the consensus test on the row just read.
  logic                                mem_we, mem_re;
  logic [ADDR_W-1:0]                   mem_waddr;
  logic [MAX_SAMPLES-1:0]              mem_be;
  logic [PIXEL_W-1:0]                  mem_wdata;
  logic [MAX_SAMPLES-1:0][PIXEL_W-1:0] mem_rdata;
  logic                                background;
  logic                                self_ok, nb_ok;

  scbc_sample_mem #(
    .DEPTH  (DEPTH),
    .LANES  (MAX_SAMPLES),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .be_i    (mem_be),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (own_addr_c),
    .rdata_o (mem_rdata)
  );

  scbc_match #(
    .LANES (MAX_SAMPLES),
    .CNT_W (CNT_W)
  ) u_match (
    .samples_i    (mem_rdata),
    .pixel_i      (pix_q),
    .radius_i     (radius_q),
    .count_i      (n_eff),
    .required_i   (required_q),
    .background_o (background)
  );

  assign self_ok = self_upd_q && (8'(self_slot_q) < 8'(n_eff));
  assign nb_ok   = nb_upd_q && (8'(nb_slot_q) < 8'(n_eff));
  assign mem_re  = accept && !is_learn;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_fg_d    = out_fg_q;
    out_learn_d = out_learn_q;
    mem_we      = 1'b0;
    mem_waddr   = own_addr_c;
    mem_be      = '0;
    mem_wdata   = pix_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_learn) begin
            mem_we      = 1'b1;
            mem_be      = MAX_SAMPLES'(1) << SLOT_W'(in_i.frame_number);
            mem_wdata   = in_i.pixel;
            out_valid_d = 1'b1;
            out_fg_d    = 1'b0;
            out_learn_d = 1'b1;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        out_valid_d = 1'b1;
        out_fg_d    = !background;
        out_learn_d = 1'b0;
        mem_waddr   = own_addr_q;
        if (background && self_ok) begin
          mem_we = 1'b1;
          mem_be = MAX_SAMPLES'(1) << SLOT_W'(self_slot_q);
        end
        state_d = (background && nb_ok) ? S_NBR : S_IDLE;
      end
      S_NBR: begin
        mem_we    = 1'b1;
        mem_waddr = nb_addr_q;
        mem_be    = MAX_SAMPLES'(1) << SLOT_W'(nb_slot_q);
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_fg_q    <= out_fg_d;
    out_learn_q <= out_learn_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.foreground = out_fg_q;
  assign out_o.learning   = out_learn_q;

`ifndef SYNTH
  // The single memory never sees a read and a write in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_re |-> !mem_we)
    else $error("sample memory read and write in the same cycle");

  // The result register is empty whenever a classification completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> !out_valid_q)
    else $error("classification result would overwrite a pending result");

  // A neighbor write always follows a classification and ends the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NBR) |-> ($past(state_q) == S_EVAL) ##1 (state_q == S_IDLE))
    else $error("neighbor write out of sequence");

  // No new transaction is taken while an item is still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_i.ready)
    else $error("input ready while an item is in flight");

  // A learning result is never reported as foreground.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_learn_q) |-> !out_fg_q)
    else $error("learning result flagged as foreground");
`endif

endmodule
